// ===== rtl/hbpd_pkg.sv =====
// hbpd_pkg: shared constants, register indexes and structs of the huffman bitmap decoder
// no dependencies; imported by hbpd_ctrl, hbpd_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package hbpd_pkg;

  // tree table size, a power of two; offsets and addresses wrap modulo this
  localparam int TreeDepth = 1024;
  localparam int TreeAw    = $clog2(TreeDepth);

  localparam logic [12:0] MaxSize = 13'd4096;

  // input word kinds
  localparam logic [1:0] ModeStart = 2'd0;
  localparam logic [1:0] ModeTree  = 2'd1;
  localparam logic [1:0] ModeData  = 2'd2;

  // register indexes
  localparam logic [2:0] RegCodewordBits = 3'd0;
  localparam logic [2:0] RegImageWidth   = 3'd1;
  localparam logic [2:0] RegImageHeight  = 3'd2;
  localparam logic [2:0] RegOriginX      = 3'd3;
  localparam logic [2:0] RegOriginY      = 3'd4;
  localparam logic [2:0] RegScreenWidth  = 3'd5;
  localparam logic [2:0] RegScreenHeight = 3'd6;

  typedef struct packed {
    logic [3:0]  codeword_bits;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [14:0] origin_x;
    logic [14:0] origin_y;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic clear;  // start of image
    logic load;   // take a packed data word
    logic walk;   // tree walk running
    logic flush;  // hand over the held pixel as last
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic flush_done;
  } sts_t;

  typedef struct packed {
    logic [15:0] color;
    logic [6:0]  alpha;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        visible;
  } pix_t;

endpackage

`default_nettype wire

// ===== rtl/hbpd_ram.sv =====
// hbpd_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module hbpd_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hbpd_ctrl.sv =====
// hbpd_ctrl: controller state machine, decodes input words and sequences walk and flush
// depends on hbpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbpd_ctrl import hbpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [9:0] tree_index,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       tree_we
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StWalk  = 3'b010,
    StFlush = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != StIdle);
  assign accept   = in_valid && (state == StIdle);

  assign cmd.clear = accept && (mode == ModeStart);
  assign cmd.load  = accept && (mode == ModeData);
  assign cmd.walk  = (state == StWalk);
  assign cmd.flush = (state == StFlush);

  // indexes past the table are dropped
  assign tree_we = accept && (mode == ModeTree) &&
                   ({22'd0, tree_index} < 32'(TreeDepth));

  always_comb begin
    state_next = state;
    case (state)
      StIdle: begin
        if (cmd.load) begin
          state_next = StWalk;
        end
      end
      StWalk: begin
        if (sts.walk_done) begin
          state_next = StFlush;
        end
      end
      StFlush: begin
        if (sts.flush_done) begin
          state_next = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hbpd_dp.sv =====
// hbpd_dp: datapath with codeword shifter, tree walk, raster counters,
// held pixel and output register; depends on hbpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbpd_dp import hbpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  cfg_t              cfg,
  input  logic [31:0]       word,
  input  logic [31:0]       ram_rdata,
  output logic              ram_re,
  output logic [TreeAw-1:0] ram_raddr,
  output sts_t              sts,
  input  logic              out_stall,
  output logic              out_valid,
  output pix_t              out_pix,
  output logic              out_last
);

  logic [31:0]       data;
  logic [5:0]        used;
  logic [TreeAw-1:0] node;
  logic              ent_vld;
  logic [11:0]       column;
  logic [11:0]       row;
  logic              done;
  logic              pend_vld;
  pix_t              pend;

  logic [3:0]        bpc;
  logic [8:0]        mask;
  logic [7:0]        code;
  logic [12:0]       w_eff;
  logic [12:0]       h_eff;
  logic              empty;
  logic              out_busy;
  logic              advance;
  logic              leaf;
  logic              issue;
  logic              emit;
  logic [TreeAw-1:0] node_eff;
  logic [15:0]       px;
  logic [15:0]       py;
  logic [12:0]       col_inc;
  logic [12:0]       row_inc;
  pix_t              new_pix;

  // codeword width, zero acts as one, large values saturate
  always_comb begin
    if (cfg.codeword_bits == 4'd0) begin
      bpc = 4'd1;
    end else if (cfg.codeword_bits > 4'd8) begin
      bpc = 4'd8;
    end else begin
      bpc = cfg.codeword_bits;
    end
  end

  assign mask  = (9'd1 << bpc) - 9'd1;
  assign code  = data[7:0] & mask[7:0];
  assign w_eff = (cfg.image_width > MaxSize) ? MaxSize : cfg.image_width;
  assign h_eff = (cfg.image_height > MaxSize) ? MaxSize : cfg.image_height;
  assign empty = (w_eff == 13'd0) || (h_eff == 13'd0);

  assign out_busy = out_valid && out_stall;
  assign advance  = cmd.walk && !(pend_vld && out_busy);
  assign leaf     = ram_rdata[31];
  assign node_eff = ent_vld ? (leaf ? '0 : ram_rdata[TreeAw-1:0]) : node;
  assign issue    = (used < 6'd32);
  assign emit     = advance && ent_vld && leaf && !done && !empty;

  assign ram_re    = advance && issue;
  assign ram_raddr = node_eff + TreeAw'(code);

  // screen position and clip test, from registers only
  assign px = {cfg.origin_x[14], cfg.origin_x} + {4'd0, column};
  assign py = {cfg.origin_y[14], cfg.origin_y} + {4'd0, row};

  assign new_pix.color   = ram_rdata[15:0];
  assign new_pix.alpha   = ram_rdata[22:16];
  assign new_pix.pos_x   = px;
  assign new_pix.pos_y   = py;
  assign new_pix.visible = !px[15] && (px < {3'd0, cfg.screen_width}) &&
                           !py[15] && (py < {3'd0, cfg.screen_height});

  assign col_inc = {1'b0, column} + 13'd1;
  assign row_inc = {1'b0, row} + 13'd1;

  assign sts.walk_done  = !ent_vld && !issue;
  assign sts.flush_done = !pend_vld || !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_vld  <= 1'b0;
      ent_vld   <= 1'b0;
      node      <= '0;
      column    <= '0;
      row       <= '0;
      done      <= 1'b0;
      used      <= 6'd32;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        node   <= '0;
        column <= '0;
        row    <= '0;
        done   <= 1'b0;
      end
      if (cmd.load) begin
        data <= word;
        used <= 6'd0;
      end
      if (advance) begin
        node    <= node_eff;
        ent_vld <= issue;
        if (issue) begin
          data <= data >> bpc;
          used <= used + {2'd0, bpc};
        end
      end
      if (emit) begin
        if (pend_vld) begin
          out_pix   <= pend;
          out_last  <= 1'b0;
          out_valid <= 1'b1;
        end
        pend     <= new_pix;
        pend_vld <= 1'b1;
        if (col_inc >= w_eff) begin
          column <= '0;
          if (row_inc >= h_eff) begin
            row  <= '0;
            done <= 1'b1;
          end else begin
            row <= row_inc[11:0];
          end
        end else begin
          column <= col_inc[11:0];
        end
      end
      if (cmd.flush && pend_vld && !out_busy) begin
        out_pix   <= pend;
        out_last  <= 1'b1;
        out_valid <= 1'b1;
        pend_vld  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/huffman_bitmap_pixel_decoder.sv =====
// huffman_bitmap_pixel_decoder: top level, config registers, tree table ram,
// controller and datapath; depends on hbpd_pkg, hbpd_ram, hbpd_ctrl, hbpd_dp
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | to block  | in_valid / in_stall  | mode, tree_index, word
//   out     | from blk  | out_valid / out_stall| color, alpha, pos_x, pos_y, visible, last
//   cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// start and tree writes are done in the accept cycle; a data word is accepted, then
// walked with one table read per codeword (32 / codeword width, rounded up, so up to 32
// codewords), then the last table read, the walk exit check and the flush follow;
// the tree lookup loop runs through the single table read port
// a stalled output holds the walk once a second pixel is waiting, so the word can
// take longer; the input stalls for the whole word
// rst is synchronous: config goes to defaults, the walk sits at the root, the
// tree table keeps whatever it held and must be written before use
`timescale 1ns / 1ps
`default_nettype none

module huffman_bitmap_pixel_decoder import hbpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [9:0]         tree_index,
  input  logic [31:0]        word,
  // decoded pixels
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        color,
  output logic [6:0]         alpha,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic               visible,
  output logic               last,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t              cfg;
  cmd_t              cmd;
  sts_t              sts;
  pix_t              out_pix;
  logic              tree_we;
  logic              ram_re;
  logic [TreeAw-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.codeword_bits <= 4'd1;
      cfg.image_width   <= 13'd128;
      cfg.image_height  <= 13'd128;
      cfg.origin_x      <= 15'd0;
      cfg.origin_y      <= 15'd0;
      cfg.screen_width  <= 13'd128;
      cfg.screen_height <= 13'd128;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegCodewordBits: cfg.codeword_bits <= cfg_data[3:0];
        RegImageWidth:   cfg.image_width   <= cfg_data[12:0];
        RegImageHeight:  cfg.image_height  <= cfg_data[12:0];
        RegOriginX:      cfg.origin_x      <= cfg_data[14:0];
        RegOriginY:      cfg.origin_y      <= cfg_data[14:0];
        RegScreenWidth:  cfg.screen_width  <= cfg_data[12:0];
        RegScreenHeight: cfg.screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // code tree table, written by tree words, read by the walk
  hbpd_ram #(
    .Width (32),
    .Depth (TreeDepth)
  ) u_tree (
    .clk   (clk),
    .we    (tree_we),
    .waddr (TreeAw'(tree_index)),
    .wdata (word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hbpd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .tree_index (tree_index),
    .sts        (sts),
    .cmd        (cmd),
    .tree_we    (tree_we)
  );

  hbpd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .word      (word),
    .ram_rdata (ram_rdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_pix   (out_pix),
    .out_last  (last)
  );

  // output word fields
  assign color   = out_pix.color;
  assign alpha   = out_pix.alpha;
  assign pos_x   = out_pix.pos_x;
  assign pos_y   = out_pix.pos_y;
  assign visible = out_pix.visible;

`ifndef ASSERT_OFF
  // a tree write and a walk lookup never share the ram in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(tree_we && ram_re))
    else $error("tree write during walk lookup");

  // no lookup while the block waits for input
  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !ram_re)
    else $error("table read while idle");

  // a new output word only comes out of a running data word
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word loaded while idle");
`endif

endmodule

`default_nettype wire
